// ----- hw/rtl/scbs_pkg.sv -----
`default_nettype none

package scbs_pkg;

  localparam int unsigned WindowDef    = 5;
  localparam int unsigned MaxWidthDef  = 2048;
  localparam int unsigned PixelBitsDef = 8;
  localparam int unsigned CfgWidth     = 12;
  localparam logic [CfgWidth-1:0] WidthReset = CfgWidth'(640);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HMUL,
    ST_HFIX,
    ST_VSUM,
    ST_VMUL,
    ST_VOUT
  } scbs_state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/scbs_if.sv -----
`default_nettype none

interface scbs_pix_if import scbs_pkg::*; #(
  parameter int unsigned PIXEL_BITS = PixelBitsDef
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;
  logic                  frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface scbs_res_if import scbs_pkg::*; #(
  parameter int unsigned PIXEL_BITS = PixelBitsDef
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] smoothed;

  modport source (output valid, output smoothed, input ready);
  modport sink   (input valid, input smoothed, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/scbs_div.sv -----
`default_nettype none

// Small-divisor divide: reciprocal multiply (registered), then one-step correction.
module scbs_div #(
  parameter int unsigned SW = 11,
  parameter int unsigned NW = 3,
  parameter int unsigned QW = 8
) (
  input  logic          clk_i,
  input  logic          ld_i,
  input  logic [SW-1:0] num_i,
  input  logic [NW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  localparam int unsigned RW = SW + 1;
  localparam int unsigned PW = SW + RW;
  localparam int unsigned BW = SW + NW;
  localparam int unsigned NDEN = 2 ** NW;

  logic [RW-1:0] recip [NDEN];
  logic [PW-1:0] prod_q;
  logic [SW-1:0] num_q;
  logic [NW-1:0] den_q;
  logic [SW-1:0] q0;
  logic [BW-1:0] back;
  logic [BW-1:0] rem;
  logic [SW-1:0] quo;

  assign recip[0] = '0;
  for (genvar g = 1; g < NDEN; g++) begin : g_rcp
    localparam logic [RW-1:0] Rcp = RW'((64'd1 << SW) / g);
    assign recip[g] = Rcp;
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      prod_q <= PW'(num_i) * PW'(recip[den_i]);
      num_q  <= num_i;
      den_q  <= den_i;
    end
  end

  always_comb begin
    q0   = prod_q[2*SW-1:SW];
    back = BW'(q0) * BW'(den_q);
    rem  = BW'(num_q) - back;
    quo  = (rem >= BW'(den_q)) ? q0 + SW'(1) : q0;
  end

  assign quo_o = QW'(quo);

endmodule

`default_nettype wire

// ----- hw/rtl/separable_causal_box_smoother.sv -----
`default_nettype none

// Causal separable box smoother. One result item per input pixel item, in order.
// For each pixel item, the line memory is read when the item is taken,
// the horizontal average goes through the shared two-stage divider, the column
// history is updated and written back, and the vertical average goes through the
// same divider into the output register. The output register lets the next pixel
// be taken while a result still waits. Reads and writes to the line memory never
// overlap for one item and the next, so no forwarding is needed. The line memory
// has no clearing pass: rows not yet seen in the current frame are never summed.
// image_width must be written only while the block is idle; the block does not
// enforce this. 0 acts as 1, values above MAX_WIDTH act as MAX_WIDTH.
module separable_causal_box_smoother import scbs_pkg::*; #(
  parameter int unsigned WINDOW     = WindowDef,
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned PIXEL_BITS = PixelBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  scbs_pix_if.sink            px_i,
  scbs_res_if.source          res_o
);

  localparam int unsigned HIST = WINDOW - 1;
  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned RSW  = $clog2(WINDOW);
  localparam int unsigned NW   = $clog2(WINDOW + 1);
  localparam int unsigned SW   = PIXEL_BITS + $clog2(WINDOW);
  localparam int unsigned MW   = HIST * PIXEL_BITS;
  localparam int unsigned EW   = ((CW > CfgWidth) ? CW : CfgWidth) + 1;

  scbs_state_e state_q, state_d;

  logic [CfgWidth-1:0]   width_q;
  logic [CW-1:0]         col_q, col_d, col_cur, col_use_q;
  logic [RSW-1:0]        rows_q, rows_d, rows_cur, rows_use_q;
  logic [PIXEL_BITS-1:0] row_win_q [HIST];

  logic [SW-1:0]         hsum_d, hsum_q, vsum_d, vsum_q;
  logic [NW-1:0]         hcnt_d, hcnt_q, vcnt_d, vcnt_q;
  logic [PIXEL_BITS-1:0] h_q;
  logic [PIXEL_BITS-1:0] out_q;
  logic                  out_valid_q;

  logic [MW-1:0]         mem [MAX_WIDTH];
  logic [MW-1:0]         rd_q;
  logic [MW-1:0]         wr_data;

  logic                  in_acc, last, wr_en, div_ld, h_ld, out_ld;
  logic [EW-1:0]         eff_last;
  logic [SW-1:0]         div_num;
  logic [NW-1:0]         div_den;
  logic [PIXEL_BITS-1:0] div_quo;

  assign px_i.ready   = (state_q == ST_IDLE);
  assign in_acc       = px_i.valid && px_i.ready;
  assign res_o.valid    = out_valid_q;
  assign res_o.smoothed = out_q;

  // position bookkeeping for the item being taken
  always_comb begin
    col_cur  = px_i.frame_start ? '0 : col_q;
    rows_cur = px_i.frame_start ? '0 : rows_q;
    if (width_q == '0) begin
      eff_last = '0;
    end else if (EW'(width_q) > EW'(MAX_WIDTH)) begin
      eff_last = EW'(MAX_WIDTH - 1);
    end else begin
      eff_last = EW'(width_q) - EW'(1);
    end
    last   = (EW'(col_cur) >= eff_last);
    col_d  = last ? '0 : col_cur + CW'(1);
    rows_d = (last && (rows_cur < RSW'(HIST))) ? rows_cur + RSW'(1) : rows_cur;
    hcnt_d = (col_cur < CW'(WINDOW)) ? NW'({1'b0, col_cur} + (CW + 1)'(1)) : NW'(WINDOW);
    hsum_d = SW'(px_i.pixel);
    for (int k = 0; k < HIST; k++) begin
      if (CW'(k) < col_cur) begin
        hsum_d = hsum_d + SW'(row_win_q[k]);
      end
    end
  end

  // vertical sum over the column history of the rows seen so far
  always_comb begin
    vcnt_d = NW'(rows_use_q) + NW'(1);
    vsum_d = SW'(h_q);
    for (int k = 0; k < HIST; k++) begin
      if (RSW'(k) < rows_use_q) begin
        vsum_d = vsum_d + SW'(rd_q[k*PIXEL_BITS +: PIXEL_BITS]);
      end
    end
    wr_data = MW'({rd_q, h_q});
  end

  always_comb begin
    state_d = state_q;
    wr_en   = 1'b0;
    div_ld  = 1'b0;
    h_ld    = 1'b0;
    out_ld  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_HMUL;
        end
      end
      ST_HMUL: begin
        div_ld  = 1'b1;
        state_d = ST_HFIX;
      end
      ST_HFIX: begin
        h_ld    = 1'b1;
        state_d = ST_VSUM;
      end
      ST_VSUM: begin
        wr_en   = 1'b1;
        state_d = ST_VMUL;
      end
      ST_VMUL: begin
        div_ld  = 1'b1;
        state_d = ST_VOUT;
      end
      ST_VOUT: begin
        if (!out_valid_q || res_o.ready) begin
          out_ld  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign div_num = (state_q == ST_HMUL) ? hsum_q : vsum_q;
  assign div_den = (state_q == ST_HMUL) ? hcnt_q : vcnt_q;

  scbs_div #(
    .SW (SW),
    .NW (NW),
    .QW (PIXEL_BITS)
  ) u_div (
    .clk_i (clk_i),
    .ld_i  (div_ld),
    .num_i (div_num),
    .den_i (div_den),
    .quo_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= WidthReset;
      col_q       <= '0;
      rows_q      <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < HIST; k++) begin
        row_win_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        col_q        <= col_d;
        rows_q       <= rows_d;
        row_win_q[0] <= px_i.pixel;
        for (int k = 1; k < HIST; k++) begin
          row_win_q[k] <= row_win_q[k-1];
        end
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col_use_q  <= col_cur;
      rows_use_q <= rows_cur;
      hsum_q     <= hsum_d;
      hcnt_q     <= hcnt_d;
    end
    if (h_ld) begin
      h_q <= div_quo;
    end
    if (state_q == ST_VSUM) begin
      vsum_q <= vsum_d;
      vcnt_q <= vcnt_d;
    end
    if (out_ld) begin
      out_q <= div_quo;
    end
  end

  // line memory: one read when an item is taken, one write-back per item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= mem[col_cur];
    end
    if (wr_en) begin
      mem[col_use_q] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/scbs_checker.sv -----
`default_nettype none

module scbs_checker import scbs_pkg::*; #(
  parameter int unsigned PIXEL_BITS = PixelBitsDef
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_i,
  input wire logic                  in_frame_start_i,
  input wire logic [PIXEL_BITS-1:0] in_pixel_i,
  input wire logic                  out_valid_i,
  input wire logic                  out_ready_i,
  input wire logic [PIXEL_BITS-1:0] out_smoothed_i
);

  localparam int unsigned Lat = 6;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_smoothed_i))
    else $error("result item changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("second item taken while one is in work");

  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_acc, Lat))
    else $error("result item without a matching input item");

  // first pixel of a frame has nothing to average with
  a_frame_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) && $past(in_acc && in_frame_start_i, Lat)
      |-> out_smoothed_i == $past(in_pixel_i, Lat))
    else $error("frame start pixel not passed through");

endmodule

bind separable_causal_box_smoother scbs_checker #(
  .PIXEL_BITS (PIXEL_BITS)
) u_scbs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (px_i.valid),
  .in_ready_i       (px_i.ready),
  .in_frame_start_i (px_i.frame_start),
  .in_pixel_i       (px_i.pixel),
  .out_valid_i      (res_o.valid),
  .out_ready_i      (res_o.ready),
  .out_smoothed_i   (res_o.smoothed)
);

`default_nettype wire

// ----- test/separable_causal_box_smoother_tb.sv -----
`timescale 1ns / 100ps

module separable_causal_box_smoother_tb;
  import scbs_pkg::*;

  localparam int unsigned HistDepth = WindowDef - 1;
  localparam int unsigned RandomItems = 1500;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_PATTERN,
    READY_LONG
  } ready_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgWidth-1:0] cfg_wdata_i;

  scbs_pix_if px_if ();
  scbs_res_if res_if ();

  separable_causal_box_smoother i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .px_i        (px_if),
    .res_o       (res_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow of the smoother state
  logic [CfgWidth-1:0]     width_shadow = WidthReset;
  int unsigned             next_column  = 0;
  int unsigned             rows_done    = 0;
  logic [PixelBitsDef-1:0] row_taps [HistDepth];
  logic [PixelBitsDef-1:0] column_taps [MaxWidthDef][HistDepth];

  logic [PixelBitsDef-1:0] expected_smoothed [$];
  int unsigned             mismatches = 0;
  int unsigned             items_sent = 0;

  ready_mode_e ready_mode = READY_ALWAYS;
  int unsigned ready_tick = 0;
  int unsigned ready_hold = 0;
  logic        ready_level = 1'b1;
  int unsigned burst_left = 0;
  int unsigned gap_max = 0;

  initial begin
    for (int k = 0; k < HistDepth; k++) row_taps[k] = '0;
  end

  function automatic logic [PixelBitsDef-1:0] predict_smoothed(
    input logic [PixelBitsDef-1:0] pix,
    input logic                    fs
  );
    int unsigned col, hcount, vcount, acc, hval, eff_width;
    if (fs) begin
      next_column = 0;
      rows_done = 0;
    end
    col = next_column % MaxWidthDef;

    hcount = (col + 1 < WindowDef) ? col + 1 : WindowDef;
    acc = pix;
    for (int k = 0; k + 1 < hcount; k++) acc += row_taps[k];
    hval = acc / hcount;
    for (int k = HistDepth - 1; k > 0; k--) row_taps[k] = row_taps[k-1];
    row_taps[0] = pix;

    vcount = rows_done + 1;
    acc = hval;
    for (int k = 0; k + 1 < vcount; k++) acc += column_taps[col][k];
    for (int k = HistDepth - 1; k > 0; k--) column_taps[col][k] = column_taps[col][k-1];
    column_taps[col][0] = hval[PixelBitsDef-1:0];

    eff_width = (width_shadow == 0) ? 1 :
                (width_shadow > MaxWidthDef) ? MaxWidthDef : width_shadow;
    if (col + 1 >= eff_width) begin
      next_column = 0;
      if (rows_done < HistDepth) rows_done++;
    end else begin
      next_column = col + 1;
    end
    return PixelBitsDef'(acc / vcount);
  endfunction

  function automatic logic [PixelBitsDef-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return PixelBitsDef'($urandom_range(0, 15));
      3: return PixelBitsDef'($urandom_range(240, 255));
      default: return PixelBitsDef'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_pixel(input logic [PixelBitsDef-1:0] pix, input logic fs);
    int unsigned gap;
    logic [PixelBitsDef-1:0] want;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        @(negedge clk_i);
        px_if.valid       <= 1'b0;
        px_if.pixel       <= PixelBitsDef'($urandom);
        px_if.frame_start <= 1'($urandom);
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    px_if.valid       <= 1'b1;
    px_if.pixel       <= pix;
    px_if.frame_start <= fs;
    @(posedge clk_i);
    while (!px_if.ready) @(posedge clk_i);
    want = predict_smoothed(pix, fs);
    expected_smoothed = {expected_smoothed, want};
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    px_if.valid <= 1'b0;
    burst_left = 0;
    wait (expected_smoothed.size() == 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_image_width(input logic [CfgWidth-1:0] w);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= CfgWidth'($urandom);
    width_shadow = w;
  endtask

  // receiver back-pressure
  always @(negedge clk_i) begin
    ready_tick++;
    case (ready_mode)
      READY_ALWAYS:  res_if.ready <= 1'b1;
      READY_COIN:    res_if.ready <= 1'($urandom_range(0, 1));
      READY_PATTERN: res_if.ready <= (ready_tick % 4) != 3;
      default: begin
        if (ready_hold == 0) begin
          ready_hold  = $urandom_range(1, 16);
          ready_level = ~ready_level;
        end
        ready_hold--;
        res_if.ready <= ready_level;
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_smoothed.size() == 0) begin
        report_mismatch($sformatf("unexpected item smoothed=%0d", res_if.smoothed));
      end else begin
        if (res_if.smoothed !== expected_smoothed[0])
          report_mismatch($sformatf("smoothed got %0d want %0d",
                                    res_if.smoothed, expected_smoothed[0]));
        void'(expected_smoothed.pop_front());
      end
    end
  end

  // row 0 at reset width: horizontal window ramps up and saturates
  task automatic test_reset_width();
    ready_mode = READY_ALWAYS;
    gap_max = 0;
    send_pixel(8'd0, 1'b0);
    for (int k = 0; k < 5; k++) send_pixel(8'd255, 1'b0);
    drain_results();
  endtask

  // width zero acts as one: every pixel is its own row, vertical count saturates
  task automatic test_single_column();
    ready_mode = READY_COIN;
    write_image_width('0);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd254, 1'b0);
    send_pixel(8'd1, 1'b0);
    drain_results();
  endtask

  // frame start in the middle of a row
  task automatic test_frame_restart();
    ready_mode = READY_PATTERN;
    gap_max = 2;
    write_image_width(CfgWidth'(3));
    send_pixel(pick_pixel(), 1'b1);
    for (int k = 0; k < 6; k++) send_pixel(pick_pixel(), 1'b0);
    send_pixel(pick_pixel(), 1'b1);
    for (int k = 0; k < 4; k++) send_pixel(pick_pixel(), 1'b0);
    drain_results();
  endtask

  // width narrowed mid-frame, past the current column
  task automatic test_width_narrowed();
    ready_mode = READY_LONG;
    gap_max = 3;
    write_image_width(CfgWidth'(6));
    send_pixel(pick_pixel(), 1'b1);
    for (int k = 0; k < 15; k++) send_pixel(pick_pixel(), 1'b0);
    drain_results();
    write_image_width(CfgWidth'(2));
    for (int k = 0; k < 7; k++) send_pixel(pick_pixel(), 1'b0);
    drain_results();
  endtask

  // all-ones width clamps to the line memory size; the start of a wide row
  task automatic test_widest_row();
    ready_mode = READY_COIN;
    gap_max = 1;
    write_image_width('1);
    send_pixel(pick_pixel(), 1'b1);
    for (int k = 0; k < 40; k++) send_pixel(pick_pixel(), 1'b0);
    drain_results();
    write_image_width(CfgWidth'(MaxWidthDef));
    send_pixel(pick_pixel(), 1'b1);
    for (int k = 0; k < 6; k++) send_pixel(pick_pixel(), 1'b0);
    drain_results();
  endtask

  task automatic test_random_frames();
    int unsigned sent, w, eff, n;
    sent = 0;
    while (sent < RandomItems) begin
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 1);
        1, 2, 3, 4, 5, 6: w = $urandom_range(2, 8);
        7, 8:    w = $urandom_range(9, 40);
        default: w = $urandom_range(41, 200);
      endcase
      eff = (w == 0) ? 1 : w;
      n = eff * $urandom_range(1, 7) + $urandom_range(0, eff);
      if (n > 600) n = 600;
      if (n > RandomItems - sent) n = RandomItems - sent;
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0, 1:    gap_max = 0;
        2:       gap_max = 3;
        default: gap_max = 12;
      endcase
      write_image_width(CfgWidth'(w));
      send_pixel(pick_pixel(), 1'b1);
      for (int k = 1; k < n; k++)
        send_pixel(pick_pixel(), $urandom_range(0, 99) == 0);
      sent += n;
      drain_results();
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    px_if.valid       = 1'b0;
    px_if.pixel       = '0;
    px_if.frame_start = 1'b0;
    res_if.ready      = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_width();
    test_single_column();
    test_frame_restart();
    test_width_narrowed();
    test_widest_row();
    test_random_frames();

    wait (expected_smoothed.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout after %0d items", items_sent);
    $display("status: fail");
    $finish;
  end

endmodule
